// ===== sv/trts_pkg.sv =====
// Shared types and constants of the rate-based task scheduler.
// No dependencies; used by every module of the block.
`default_nettype none

package trts_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int RESULT_CAP    = 16;

	localparam int RATE_W  = 16;
	localparam int TIME_W  = 16;
	localparam int AVAIL_W = 32;
	localparam int SLOT_W  = 4;
	localparam int CNT_CFG_W = 5;
	localparam int DVD_W   = RATE_W + 4;

	localparam logic [RATE_W-1:0] LOOP_RATE_RST = 16'd400;
	localparam logic [CNT_CFG_W-1:0] TASK_COUNT_RST = 5'd0;

	// configuration register indexes
	localparam logic REG_LOOP_RATE  = 1'b0;
	localparam logic REG_TASK_COUNT = 1'b1;

	// request kinds on tuser
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PASS = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] interval;
		logic [TIME_W-1:0] budget;
		logic [TIME_W-1:0] duration;
	} cfg_entry_t;

	typedef struct packed {
		logic [TIME_W-1:0] last_tick;
		logic [TIME_W-1:0] count;
	} run_entry_t;

endpackage

`default_nettype wire

// ===== sv/trts_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on trts_pkg for widths.
`default_nettype none

module trts_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [trts_pkg::DVD_W-1:0]   dividend,
	input  wire logic [trts_pkg::RATE_W-1:0]  divisor,
	output logic                              done,
	output logic [trts_pkg::DVD_W-1:0]        quot
);

	localparam int N  = trts_pkg::DVD_W;
	localparam int DW = trts_pkg::RATE_W;
	localparam int CW = $clog2(N + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic [N-1:0]  quo_q;

	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic          ge;

	assign shifted = {rem_q, quo_q[N-1]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

`default_nettype wire

// ===== sv/trts_table.sv =====
// Task table: entry settings written by loads, run history written by passes.
// Both read at one address with registered data. Depends on trts_pkg.
`default_nettype none

module trts_table #(
	parameter int MAX_TASKS = trts_pkg::MAX_TASKS_DEF,
	parameter int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rd_en,
	input  wire logic [IDX_W-1:0]      rd_addr,
	input  wire logic                  cfg_we,
	input  wire logic [IDX_W-1:0]      cfg_waddr,
	input  wire trts_pkg::cfg_entry_t  cfg_wdata,
	input  wire logic                  run_we,
	input  wire logic [IDX_W-1:0]      run_waddr,
	input  wire trts_pkg::run_entry_t  run_wdata,
	output trts_pkg::cfg_entry_t       rd_cfg,
	output trts_pkg::run_entry_t       rd_run
);

	trts_pkg::cfg_entry_t cfg_mem [MAX_TASKS];
	trts_pkg::run_entry_t run_mem [MAX_TASKS];

	logic [MAX_TASKS-1:0] run_vld_q;
	logic                 rd_vld_q;
	trts_pkg::cfg_entry_t rd_cfg_q;
	trts_pkg::run_entry_t rd_run_q;

	always_ff @(posedge clk) begin
		if (cfg_we) begin
			cfg_mem[cfg_waddr] <= cfg_wdata;
		end
		if (run_we) begin
			run_mem[run_waddr] <= run_wdata;
		end
		if (rd_en) begin
			rd_cfg_q <= cfg_mem[rd_addr];
			rd_run_q <= run_mem[rd_addr];
		end
	end

	// history reads as zero until first written after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (run_we) begin
				run_vld_q[run_waddr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= run_vld_q[rd_addr];
			end
		end
	end

	assign rd_cfg = rd_cfg_q;
	assign rd_run = rd_vld_q ? rd_run_q : '0;

endmodule

`default_nettype wire

// ===== sv/tick_rate_task_scheduler.sv =====
// Rate-based task scheduler. A load request (tuser 0) with an in-range slot stores
// one task entry; its interval comes from a bit-serial divider, which is skipped
// when the rate is zero. A pass request (tuser 1) advances the tick and walks the
// entries in order, each with a table read, then an evaluate step, and ends with a
// finish step; it walks n = min(task_count, MAX_TASKS, 16) entries, fewer when the
// budget runs out, and waits while the output stalls. Results of a pass follow on
// the master side, tlast on the final one. The input is not ready until the current
// request is done. Depends on trts_pkg, trts_div and trts_table.
`default_nettype none

module tick_rate_task_scheduler #(
	parameter int MAX_TASKS = trts_pkg::MAX_TASKS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// task_slot[3:0], rate_q4[19:4], budget_us[35:20], duration_us[51:36],
	// time_budget[83:52], zero fill
	input  wire logic [87:0] s_axis_tdata,
	// cmd[0]
	input  wire logic        s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// chosen_task[3:0], time_left[35:4], times_run[51:36], zero fill
	output logic [55:0]      m_axis_tdata,
	// ran[0]
	output logic             m_axis_tuser,
	output logic             m_axis_tlast
);

	localparam int IDX_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W    = IDX_W + 1;
	localparam int SCAN_MAX = (MAX_TASKS < trts_pkg::RESULT_CAP) ? MAX_TASKS
	                                                            : trts_pkg::RESULT_CAP;
	localparam int TW = trts_pkg::TIME_W;
	localparam int AW = trts_pkg::AVAIL_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EV   = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	// request fields
	logic [3:0]    in_slot;
	logic [15:0]   in_rate;
	logic [TW-1:0] in_budget;
	logic [TW-1:0] in_dur;
	logic [AW-1:0] in_avail;

	assign in_slot   = s_axis_tdata[3:0];
	assign in_rate   = s_axis_tdata[19:4];
	assign in_budget = s_axis_tdata[35:20];
	assign in_dur    = s_axis_tdata[51:36];
	assign in_avail  = s_axis_tdata[83:52];

	// control state
	logic [2:0]       state_q, state_nx;
	logic [15:0]      loop_rate_q;
	logic [4:0]       task_count_q;
	logic [TW-1:0]    tick_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] n_q;
	logic             pend_vld_q;
	logic             m_vld_q;

	// payload
	logic [IDX_W-1:0] ld_slot_q;
	logic             ld_zero_q;
	logic [TW-1:0]    ld_budget_q;
	logic [TW-1:0]    ld_dur_q;
	logic [AW-1:0]    avail_q;
	logic [3:0]       pend_task_q;
	logic [AW-1:0]    pend_left_q;
	logic [TW-1:0]    pend_count_q;
	logic [3:0]       out_task_q;
	logic             out_ran_q;
	logic [AW-1:0]    out_left_q;
	logic [TW-1:0]    out_count_q;
	logic             out_last_q;

	logic                       accept;
	logic                       div_start;
	logic                       div_done;
	logic [trts_pkg::DVD_W-1:0] div_quot;
	logic [TW-1:0]              interval;

	trts_pkg::cfg_entry_t rd_cfg;
	trts_pkg::run_entry_t rd_run;
	trts_pkg::cfg_entry_t cfg_wdata;
	trts_pkg::run_entry_t run_wdata;
	logic                 cfg_we;
	logic                 run_we;
	logic                 rd_en;

	logic [TW-1:0]    dt;
	logic             hit;
	logic             stop;
	logic [AW-1:0]    new_left;
	logic [TW-1:0]    new_count;
	logic             out_free;
	logic             is_end;
	logic             ev_go;
	logic             m_load;
	logic [CNT_W-1:0] n_start;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_free      = !m_vld_q || m_axis_tready;

	assign div_start = accept && (s_axis_tuser == trts_pkg::CMD_LOAD) && (in_rate != '0);

	trts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({loop_rate_q, 4'b0000}),
		.divisor  (in_rate),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_comb begin
		if (ld_zero_q || div_quot == '0) begin
			interval = TW'(1);
		end else if (div_quot[trts_pkg::DVD_W-1:TW] != '0) begin
			interval = '1;
		end else begin
			interval = div_quot[TW-1:0];
		end
	end

	assign cfg_we    = (state_q == S_DIV) && (ld_zero_q || div_done);
	assign cfg_wdata = '{interval: interval, budget: ld_budget_q, duration: ld_dur_q};

	// pass evaluation
	assign dt        = tick_q - rd_run.last_tick;
	assign hit       = (dt >= rd_cfg.interval) && ({16'd0, rd_cfg.budget} <= avail_q);
	assign stop      = {16'd0, rd_cfg.duration} >= avail_q;
	assign new_left  = stop ? '0 : avail_q - {16'd0, rd_cfg.duration};
	assign new_count = rd_run.count + TW'(1);
	assign is_end    = ({1'b0, idx_q} + CNT_W'(1)) == n_q;
	assign ev_go     = !hit || !pend_vld_q || out_free;
	assign m_load    = ((state_q == S_EV) && ev_go && hit && pend_vld_q) ||
	                   ((state_q == S_FIN) && out_free);

	assign run_we    = (state_q == S_EV) && hit && ev_go;
	assign run_wdata = '{last_tick: tick_q, count: new_count};
	assign rd_en     = (state_q == S_RD);

	assign n_start = (32'(task_count_q) > SCAN_MAX) ? CNT_W'(SCAN_MAX)
	                                                : CNT_W'(task_count_q);

	trts_table #(
		.MAX_TASKS (MAX_TASKS),
		.IDX_W     (IDX_W)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rd_en),
		.rd_addr   (idx_q),
		.cfg_we    (cfg_we),
		.cfg_waddr (ld_slot_q),
		.cfg_wdata (cfg_wdata),
		.run_we    (run_we),
		.run_waddr (idx_q),
		.run_wdata (run_wdata),
		.rd_cfg    (rd_cfg),
		.rd_run    (rd_run)
	);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_axis_tuser == trts_pkg::CMD_PASS) begin
						state_nx = (n_start == '0) ? S_FIN : S_RD;
					end else if (32'(in_slot) < MAX_TASKS) begin
						state_nx = S_DIV;
					end
				end
			end
			S_DIV: begin
				if (cfg_we) begin
					state_nx = S_IDLE;
				end
			end
			S_RD: begin
				state_nx = S_EV;
			end
			S_EV: begin
				if (ev_go) begin
					state_nx = ((hit && stop) || is_end) ? S_FIN : S_RD;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			loop_rate_q  <= trts_pkg::LOOP_RATE_RST;
			task_count_q <= trts_pkg::TASK_COUNT_RST;
			tick_q       <= '0;
			idx_q        <= '0;
			n_q          <= '0;
			pend_vld_q   <= 1'b0;
			m_vld_q      <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					trts_pkg::REG_LOOP_RATE:  loop_rate_q  <= cfg_data;
					trts_pkg::REG_TASK_COUNT: task_count_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (m_load) begin
				m_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && s_axis_tuser == trts_pkg::CMD_PASS) begin
						tick_q     <= tick_q + TW'(1);
						idx_q      <= '0;
						n_q        <= n_start;
						pend_vld_q <= 1'b0;
					end
				end
				S_EV: begin
					if (ev_go) begin
						idx_q <= idx_q + IDX_W'(1);
						if (hit) begin
							pend_vld_q <= 1'b1;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						pend_vld_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ld_slot_q   <= IDX_W'(in_slot);
					ld_zero_q   <= (in_rate == '0);
					ld_budget_q <= in_budget;
					ld_dur_q    <= in_dur;
					avail_q     <= in_avail;
				end
			end
			S_EV: begin
				if (ev_go && hit) begin
					avail_q      <= new_left;
					pend_task_q  <= 4'(idx_q);
					pend_left_q  <= new_left;
					pend_count_q <= new_count;
					if (pend_vld_q) begin
						out_task_q  <= pend_task_q;
						out_ran_q   <= 1'b1;
						out_left_q  <= pend_left_q;
						out_count_q <= pend_count_q;
						out_last_q  <= 1'b0;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_last_q <= 1'b1;
					if (pend_vld_q) begin
						out_task_q  <= pend_task_q;
						out_ran_q   <= 1'b1;
						out_left_q  <= pend_left_q;
						out_count_q <= pend_count_q;
					end else begin
						out_task_q  <= '0;
						out_ran_q   <= 1'b0;
						out_left_q  <= avail_q;
						out_count_q <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = {4'b0000, out_count_q, out_left_q, out_task_q};
	assign m_axis_tuser  = out_ran_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
